FILE: hw/rtl/ccpe_pkg.sv
// shared constants for the circle cover point eraser
`timescale 1ns / 1ps

package ccpe_pkg;

    // table geometry
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 14;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int CMD_W      = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CIRCLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // sequencer states
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] S_IDLE = 2'd0;
    localparam logic [ST_W-1:0] S_WALK = 2'd1;
    localparam logic [ST_W-1:0] S_DONE = 2'd2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [IDX_W-1:0]   index_t;

endpackage

FILE: hw/rtl/circle_cover_point_eraser_unit.sv
// circle cover point eraser: point table with circle erase walk
// results: add, clear and unused commands give their result in the cycle after the transfer
// circle: the walk takes one table entry per cycle
//   through a read, difference, square and compare pipeline on single-read-port table memories
// throughput: one item at a time; input stalls from a circle transfer until its result
// reset: counters and handshake clear at once; the point memory is not cleared, the fill
//   count hides stale entries, so no clearing pass follows reset
`timescale 1ns / 1ps

module circle_cover_point_eraser_unit
    import ccpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] circle_radius,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CNT_W-1:0]   live_points,
    output logic [CNT_W-1:0]   removed_now,
    output logic               table_full
);

    // control state
    logic [ST_W-1:0] state_reg, state_next;
    count_t          fill_reg, fill_next;
    count_t          alive_reg, alive_next;
    count_t          issue_reg, issue_next;
    count_t          gone_reg, gone_next;
    logic            out_valid_reg, out_valid_next;

    // circle operands
    coord_t           cx_reg, cy_reg;
    logic [SQ_W-1:0]  r2_reg;

    // walk pipeline
    logic            v1_reg, v2_reg, v3_reg;
    index_t          idx1_reg, idx2_reg, idx3_reg;
    coord_t          dx2_reg, dy2_reg;
    logic            alive2_reg, alive3_reg;
    logic [SQ_W-1:0] sqx3_reg, sqy3_reg;

    // output payload
    count_t live_reg, removed_reg;
    logic   full_reg;

    // memory ports
    logic                  xy_we, alive_we, rd_en;
    index_t                wr_idx, rd_idx;
    logic [2*COORD_W-1:0]  xy_rdata;
    logic                  alive_wdata, alive_rdata;

    logic       in_xfer, out_free, issue_more, hit, add_ok;
    coord_t     rx, ry, dx, dy;
    logic [D2_W-1:0] d2;

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign add_ok   = (fill_reg != count_t'(MAX_POINTS));

    // point coordinate table
    ccpe_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_xy_ram (
        .clk   (clk),
        .we    (xy_we),
        .waddr (wr_idx),
        .wdata ({pos_x, pos_y}),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (xy_rdata)
    );

    // live flag table
    ccpe_ram #(
        .WIDTH (1),
        .DEPTH (MAX_POINTS)
    ) u_alive_ram (
        .clk   (clk),
        .we    (alive_we),
        .waddr (wr_idx),
        .wdata (alive_wdata),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (alive_rdata)
    );

    // read issue over the filled entries
    assign issue_more = (state_reg == S_WALK) && (issue_reg != fill_reg);
    assign rd_en      = issue_more;
    assign rd_idx     = issue_reg[IDX_W-1:0];

    // absolute coordinate differences
    assign rx = xy_rdata[2*COORD_W-1:COORD_W];
    assign ry = xy_rdata[COORD_W-1:0];
    assign dx = (rx >= cx_reg) ? (rx - cx_reg) : (cx_reg - rx);
    assign dy = (ry >= cy_reg) ? (ry - cy_reg) : (cy_reg - ry);

    // distance compare at the last stage
    assign d2  = {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
    assign hit = v3_reg && alive3_reg && (d2 <= {1'b0, r2_reg});

    // memory write steering: adds in idle, erases during the walk
    always_comb
    begin
        xy_we       = 1'b0;
        alive_we    = 1'b0;
        alive_wdata = 1'b0;
        wr_idx      = idx3_reg;
        if (state_reg == S_WALK)
        begin
            alive_we = hit;
        end
        else if (in_xfer && (command == CMD_ADD) && add_ok)
        begin
            xy_we       = 1'b1;
            alive_we    = 1'b1;
            alive_wdata = 1'b1;
            wr_idx      = fill_reg[IDX_W-1:0];
        end
    end

    // sequencer and counters
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        alive_next     = alive_reg;
        issue_next     = issue_reg;
        gone_next      = gone_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (command)
                        CMD_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (add_ok)
                            begin
                                fill_next  = fill_reg + count_t'(1);
                                alive_next = alive_reg + count_t'(1);
                            end
                        end
                        CMD_CIRCLE:
                        begin
                            state_next = S_WALK;
                            issue_next = '0;
                            gone_next  = '0;
                        end
                        CMD_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            fill_next      = '0;
                            alive_next     = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (issue_more)
                begin
                    issue_next = issue_reg + count_t'(1);
                end
                if (hit)
                begin
                    gone_next = gone_reg + count_t'(1);
                end
                if (!issue_more && !v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    alive_next     = (gone_reg <= alive_reg) ? (alive_reg - gone_reg) : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            alive_reg     <= '0;
            issue_reg     <= '0;
            gone_reg      <= '0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            alive_reg     <= alive_next;
            issue_reg     <= issue_next;
            gone_reg      <= gone_next;
            out_valid_reg <= out_valid_next;
            v1_reg        <= issue_more;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
        end
    end

    // circle operands, squared radius computed at the transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer && (command == CMD_CIRCLE))
        begin
            cx_reg <= pos_x;
            cy_reg <= pos_y;
            r2_reg <= SQ_W'(circle_radius) * SQ_W'(circle_radius);
        end
    end

    // walk pipeline payload
    always_ff @(posedge clk)
    begin
        idx1_reg   <= rd_idx;
        idx2_reg   <= idx1_reg;
        dx2_reg    <= dx;
        dy2_reg    <= dy;
        alive2_reg <= alive_rdata;
        idx3_reg   <= idx2_reg;
        alive3_reg <= alive2_reg;
        sqx3_reg   <= SQ_W'(dx2_reg) * SQ_W'(dx2_reg);
        sqy3_reg   <= SQ_W'(dy2_reg) * SQ_W'(dy2_reg);
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_xfer)
        begin
            live_reg    <= alive_next;
            removed_reg <= '0;
            full_reg    <= (command == CMD_ADD) && !add_ok;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            live_reg    <= alive_next;
            removed_reg <= gone_reg;
            full_reg    <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign live_points = live_reg;
    assign removed_now = removed_reg;
    assign table_full  = full_reg;

endmodule

FILE: hw/rtl/ccpe_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module ccpe_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/circle_cover_point_eraser_checker.sv
// checker for the circle cover point eraser: point table prediction and result compare
`timescale 1ns / 1ps

module circle_cover_point_eraser_checker
    import ccpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] circle_radius,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [CNT_W-1:0]   live_points,
    input  logic [CNT_W-1:0]   removed_now,
    input  logic               table_full,
    output int                 mismatch_count,
    output int                 pending_count
);

    typedef struct packed {
        count_t live;
        count_t removed;
        logic   full;
    } tally_t;

    // shadow copy of the point table
    coord_t      table_x    [MAX_POINTS];
    coord_t      table_y    [MAX_POINTS];
    logic        table_live [MAX_POINTS];
    int unsigned filled;
    int unsigned live_total;

    tally_t expected_tallies[$];

    // apply one command to the shadow table and return the tally it should produce
    function automatic tally_t predict_tally(logic [CMD_W-1:0] cmd, coord_t x, coord_t y,
                                             coord_t r);
        tally_t      t;
        int unsigned gone;
        int          dx;
        int          dy;
        longint      d2;
        longint      r2;
        gone   = 0;
        t.full = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                // dropped once every slot has been used since the last clear
                if (filled >= MAX_POINTS)
                begin
                    t.full = 1'b1;
                end
                else
                begin
                    table_x[filled]    = x;
                    table_y[filled]    = y;
                    table_live[filled] = 1'b1;
                    filled++;
                    live_total++;
                end
            end
            CMD_CIRCLE:
            begin
                // exact squared distance against squared radius, boundary inclusive
                r2 = longint'(r) * longint'(r);
                for (int i = 0; i < filled; i++)
                begin
                    if (table_live[i])
                    begin
                        dx = int'(table_x[i]) - int'(x);
                        dy = int'(table_y[i]) - int'(y);
                        d2 = longint'(dx) * dx + longint'(dy) * dy;
                        if (d2 <= r2)
                        begin
                            table_live[i] = 1'b0;
                            gone++;
                        end
                    end
                end
                live_total = (gone <= live_total) ? live_total - gone : 0;
            end
            CMD_CLEAR:
            begin
                foreach (table_live[i])
                    table_live[i] = 1'b0;
                filled     = 0;
                live_total = 0;
            end
            default:
            begin
                // unused code leaves the table alone
            end
        endcase
        t.live    = count_t'(live_total);
        t.removed = count_t'(gone);
        return t;
    endfunction

    // compare each result transfer, then record the expectation of each input transfer
    always @(posedge clk or negedge rst_n)
    begin
        tally_t want;
        if (!rst_n)
        begin
            foreach (table_live[i])
                table_live[i] = 1'b0;
            filled     = 0;
            live_total = 0;
            expected_tallies.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tallies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result: live %0d removed %0d full %0b",
                                 $realtime, live_points, removed_now, table_full);
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    if (live_points !== want.live || removed_now !== want.removed ||
                        table_full !== want.full)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("%0t: mismatch: expected live %0d removed %0d full %0b,",
                                   $realtime, want.live, want.removed, want.full);
                            $display(" got live %0d removed %0d full %0b",
                                     live_points, removed_now, table_full);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_tallies.push_back(predict_tally(command, pos_x, pos_y,
                                                         circle_radius));
            pending_count = expected_tallies.size();
        end
    end

endmodule

FILE: tb/circle_cover_point_eraser_unit_tb.sv
// testbench top for the circle cover point eraser: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module circle_cover_point_eraser_unit_tb;
    import ccpe_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int COORD_TOP   = (1 << COORD_W) - 1;
    localparam int RANDOM_ITEMS = 560;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   command = CMD_ADD;
    logic [COORD_W-1:0] pos_x = '0;
    logic [COORD_W-1:0] pos_y = '0;
    logic [COORD_W-1:0] circle_radius = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CNT_W-1:0]   live_points;
    logic [CNT_W-1:0]   removed_now;
    logic               table_full;
    int                 mismatch_count;
    int                 pending_count;

    // stimulus bookkeeping: points added since the last clear
    coord_t seen_x[$];
    coord_t seen_y[$];
    int     added = 0;
    int     items_sent = 0;
    logic   calm = 1'b0;
    int     stall_hold = 0;

    circle_cover_point_eraser_unit dut (.*);

    circle_cover_point_eraser_checker checker_i (.*);

    always #6 clk = ~clk;

    // gap length: mostly short, now and then long
    function automatic int idle_span();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure in bursts, off while calm
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold--;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall  <= ($urandom_range(0, 99) < 30);
            stall_hold = idle_span() - 1;
        end
    end

    // one input transfer, then an optional idle gap
    task automatic send_item(logic [CMD_W-1:0] cmd, int x, int y, int r);
        int gap;
        command       <= cmd;
        pos_x         <= coord_t'(x);
        pos_y         <= coord_t'(y);
        circle_radius <= coord_t'(r);
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (cmd == CMD_ADD && added < MAX_POINTS)
        begin
            seen_x.push_back(coord_t'(x));
            seen_y.push_back(coord_t'(y));
            added++;
        end
        else if (cmd == CMD_CLEAR)
        begin
            seen_x.delete();
            seen_y.delete();
            added = 0;
        end
        gap = (calm || $urandom_range(0, 1)) ? 0 : idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int any_coord();
        return $urandom_range(0, COORD_TOP);
    endfunction

    // clustered points followed by circles that land on them
    task automatic run_cluster();
        int bx;
        int by;
        int k;
        bx = $urandom_range(0, COORD_TOP - 64);
        by = $urandom_range(0, COORD_TOP - 64);
        if ($urandom_range(0, 99) < 50 || added > 200)
            send_item(CMD_CLEAR, any_coord(), any_coord(), any_coord());
        repeat ($urandom_range(1, 40))
        begin
            if (seen_x.size() > 0 && $urandom_range(0, 99) < 20)
            begin
                k = $urandom_range(0, seen_x.size() - 1);
                send_item(CMD_ADD, int'(seen_x[k]), int'(seen_y[k]), any_coord());
            end
            else
            begin
                send_item(CMD_ADD, bx + $urandom_range(0, 63), by + $urandom_range(0, 63),
                          any_coord());
            end
        end
        repeat ($urandom_range(1, 4))
        begin
            if (seen_x.size() > 0 && $urandom_range(0, 99) < 30)
            begin
                k = $urandom_range(0, seen_x.size() - 1);
                send_item(CMD_CIRCLE, int'(seen_x[k]), int'(seen_y[k]),
                          $urandom_range(0, 3));
            end
            else
            begin
                send_item(CMD_CIRCLE, bx + $urandom_range(0, 63), by + $urandom_range(0, 63),
                          $urandom_range(0, 48));
            end
        end
    endtask

    // fully random commands and fields
    task automatic run_noise();
        repeat ($urandom_range(1, 6))
            send_item(CMD_W'($urandom_range(CMD_ADD, CMD_UNUSED)), any_coord(), any_coord(),
                      any_coord());
    endtask

    // run limit
    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int start_count;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, unused code, extreme coordinates
        send_item(CMD_CIRCLE, 0, 0, COORD_TOP);
        send_item(CMD_UNUSED, COORD_TOP, COORD_TOP, COORD_TOP);
        send_item(CMD_ADD, 0, 0, 0);
        send_item(CMD_ADD, COORD_TOP, COORD_TOP, COORD_TOP);
        send_item(CMD_ADD, 10000, 10000, 0);
        send_item(CMD_ADD, 0, COORD_TOP, 0);
        send_item(CMD_ADD, COORD_TOP, 0, 0);
        // duplicates and points on the circle boundary
        send_item(CMD_ADD, 5, 5, 0);
        send_item(CMD_ADD, 5, 5, 0);
        send_item(CMD_ADD, 5, 6, 0);
        send_item(CMD_ADD, 10, 5, 0);
        send_item(CMD_UNUSED, 0, 0, 0);
        send_item(CMD_CIRCLE, 5, 5, 0);
        send_item(CMD_CIRCLE, 5, 5, 1);
        send_item(CMD_CIRCLE, 5, 5, 5);
        send_item(CMD_CIRCLE, 0, 0, COORD_TOP);
        send_item(CMD_CIRCLE, COORD_TOP, COORD_TOP, 0);
        // clear does not count as removal, cleared points stay gone
        send_item(CMD_ADD, 1, 2, 0);
        send_item(CMD_CLEAR, COORD_TOP, COORD_TOP, COORD_TOP);
        send_item(CMD_CIRCLE, 1, 2, 0);

        // random: mostly clustered sequences, some noise
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 80)
                run_cluster();
            else
                run_noise();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        // drain outstanding results, then watch for strays
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
